### design/dssh_pkg.sv
// package for the dual stepper sequencer with homing
// holds field widths, command codes, register indexes, reset values and the phase table
// no dependencies
package dssh_pkg;

    localparam int POSITION_BITS_DEF     = 16;
    localparam int SWITCH_COUNT_BITS_DEF = 4;

    // fixed field widths
    localparam int STEP_BITS    = 16;
    localparam int OUT_POS_BITS = 16;
    localparam int DETECT_BITS  = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int IN_DATA_BITS   = 24;
    localparam int OUT_DATA_BITS  = 48;
    localparam int OUT_USED_BITS  = 43;

    localparam int REVERSE_FLOOR = 10;

    typedef enum logic [1:0] {
        CMD_STOP = 2'd0,
        CMD_FWD  = 2'd1,
        CMD_BACK = 2'd2,
        CMD_HOME = 2'd3
    } cmd_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_POSITION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_OFFSET  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DETECT_COUNT = 2'd2;

    localparam logic [15:0]            MAX_POSITION_RST = 16'd2000;
    localparam logic [15:0]            ZERO_OFFSET_RST  = 16'd20;
    localparam logic [DETECT_BITS-1:0] DETECT_COUNT_RST = 4'd3;

    // full-step gray sequence 0,1,3,2
    function automatic logic [1:0] gray_phase(input logic [1:0] idx);
        logic [1:0] pat;
        case (idx)
            2'd0:    pat = 2'b00;
            2'd1:    pat = 2'b01;
            2'd2:    pat = 2'b11;
            2'd3:    pat = 2'b10;
            default: pat = 2'b00;
        endcase
        return pat;
    endfunction

endpackage

### design/dual_stepper_sequencer_with_homing_unit.sv
// Dual stepper sequencer with homing: two full-step motors served by alternating tick words
// Usage: s_axis words carry ticks (tuser = 0) or command loads (tuser = 1); each accepted
// word produces one m_axis word with both motors' coil enables, phases, commands,
// positions and the home-fail flag as they stand after that word.
// The cfg channel writes max_position (index 0), zero_offset (1) and switch_detect_count
// (2); other indexes are ignored. cfg_ready is always high; write only while idle.
// Path: an accepted word is registered in the input register, worked on by the
// combinational tick and command logic and then registered in the result register,
// from which it shows on m_axis.
// Throughput: one word per cycle while m_axis_tready is high; a tick is one pass of compare
// and counter logic on the served motor's registers, between input and result registers.
// Stall: when m_axis_tready is low the result is held, the input register still fills
// once, and s_axis_tready then drops until the result is taken.
// Reset (rst_n low, asynchronous): both motors stopped at position 0, coils off, phase 0,
// debounce counters cleared, registers at 2000, 20 and 3, first tick serves motor A.
// Depends on dssh_pkg.
module dual_stepper_sequencer_with_homing_unit
    import dssh_pkg::*;
#(
    parameter int POSITION_BITS     = POSITION_BITS_DEF,
    parameter int SWITCH_COUNT_BITS = SWITCH_COUNT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // motor_select, command[2:1], step_count[18:3], switch_a_level, switch_b_level, pad
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    // mode
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // coil_enable_a, coil_enable_b, phase_a[3:2], phase_b[5:4], state_a[7:6],
    // state_b[9:8], position_a[25:10], position_b[41:26], home_fail[42], pad
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int PW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam int CW = (SWITCH_COUNT_BITS > DETECT_BITS) ? SWITCH_COUNT_BITS : DETECT_BITS;
    localparam logic [SWITCH_COUNT_BITS-1:0] SWC_MAX = {SWITCH_COUNT_BITS{1'b1}};

    // configuration
    logic [15:0]            max_position_reg;
    logic [15:0]            zero_offset_reg;
    logic [DETECT_BITS-1:0] detect_count_reg;

    // input stage
    logic                 in_valid_reg;
    logic                 in_mode_reg;
    logic                 in_sel_reg;
    cmd_t                 in_cmd_reg;
    logic [STEP_BITS-1:0] in_steps_reg;
    logic [1:0]           in_sw_reg;

    // motor state
    logic                         served_reg, served_next;
    cmd_t                         cmd_reg   [2];
    cmd_t                         cmd_next  [2];
    logic [STEP_BITS-1:0]         rem_reg   [2];
    logic [STEP_BITS-1:0]         rem_next  [2];
    logic [POSITION_BITS-1:0]     pos_reg   [2];
    logic [POSITION_BITS-1:0]     pos_next  [2];
    logic [1:0]                   idx_reg   [2];
    logic [1:0]                   idx_next  [2];
    logic [SWITCH_COUNT_BITS-1:0] swc_reg   [2];
    logic [SWITCH_COUNT_BITS-1:0] swc_next  [2];
    logic                         coil_reg  [2];
    logic                         coil_next [2];
    logic [1:0]                   pat_reg   [2];
    logic [1:0]                   pat_next  [2];
    logic                         fail_next;

    // result stage
    logic                     out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic [OUT_DATA_BITS-1:0] out_data_next;

    logic advance;
    logic in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_position_reg <= MAX_POSITION_RST;
            zero_offset_reg  <= ZERO_OFFSET_RST;
            detect_count_reg <= DETECT_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_POSITION: max_position_reg <= cfg_data;
                REG_ZERO_OFFSET:  zero_offset_reg  <= cfg_data;
                REG_DETECT_COUNT: detect_count_reg <= cfg_data[DETECT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg  <= s_axis_tuser;
            in_sel_reg   <= s_axis_tdata[0];
            in_cmd_reg   <= cmd_t'(s_axis_tdata[2:1]);
            in_steps_reg <= s_axis_tdata[18:3];
            in_sw_reg    <= s_axis_tdata[20:19];
        end
    end

    always_comb
    begin
        logic                         m;
        cmd_t                         c;
        logic [STEP_BITS-1:0]         r;
        logic [POSITION_BITS-1:0]     p;
        logic [1:0]                   i;
        logic [SWITCH_COUNT_BITS-1:0] s;
        logic                         coil;
        logic [1:0]                   pat;
        logic                         lvl;

        cmd_next    = cmd_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        swc_next    = swc_reg;
        coil_next   = coil_reg;
        pat_next    = pat_reg;
        served_next = served_reg;
        fail_next   = 1'b0;

        m    = ~served_reg;
        c    = cmd_reg[m];
        r    = rem_reg[m];
        p    = pos_reg[m];
        i    = idx_reg[m];
        s    = swc_reg[m];
        coil = coil_reg[m];
        pat  = pat_reg[m];
        lvl  = m ? in_sw_reg[1] : in_sw_reg[0];

        if (advance)
        begin
            if (in_mode_reg)
            begin
                cmd_next[in_sel_reg] = in_cmd_reg;
                rem_next[in_sel_reg] = in_steps_reg;
            end
            else
            begin
                served_next = m;
                case (c)
                    CMD_FWD:
                    begin
                        if (r == '0 || PW'(p) >= PW'(max_position_reg))
                        begin
                            c = CMD_STOP;
                        end
                        else
                        begin
                            coil = 1'b1;
                            pat  = gray_phase(i);
                            i    = i + 2'd1;
                            p    = p + POSITION_BITS'(1);
                            r    = r - STEP_BITS'(1);
                        end
                    end
                    CMD_BACK, CMD_HOME:
                    begin
                        if (c == CMD_BACK && r == '0)
                        begin
                            c = CMD_STOP;
                        end
                        else if (p < POSITION_BITS'(REVERSE_FLOOR))
                        begin
                            c         = CMD_STOP;
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            coil = 1'b1;
                            pat  = gray_phase(i);
                            i    = i - 2'd1;
                            p    = p - POSITION_BITS'(1);
                            if (c == CMD_BACK)
                            begin
                                r = r - STEP_BITS'(1);
                            end
                            // switch is active low; counter saturates at detect count or at its all-ones value
                            if (!lvl)
                            begin
                                if (CW'(s) < CW'(detect_count_reg) && s != SWC_MAX)
                                begin
                                    s = s + SWITCH_COUNT_BITS'(1);
                                end
                            end
                            else if (s != '0)
                            begin
                                s = s - SWITCH_COUNT_BITS'(1);
                            end
                            if (CW'(s) >= CW'(detect_count_reg))
                            begin
                                c = CMD_STOP;
                                p = POSITION_BITS'(zero_offset_reg);
                            end
                        end
                    end
                    default:
                    begin
                        c = CMD_STOP;
                    end
                endcase
                if (c == CMD_STOP)
                begin
                    coil = 1'b0;
                end
                cmd_next[m]  = c;
                rem_next[m]  = r;
                pos_next[m]  = p;
                idx_next[m]  = i;
                swc_next[m]  = s;
                coil_next[m] = coil;
                pat_next[m]  = pat;
            end
        end

        out_data_next = {
            {(OUT_DATA_BITS - OUT_USED_BITS){1'b0}},
            fail_next,
            OUT_POS_BITS'(pos_next[1]),
            OUT_POS_BITS'(pos_next[0]),
            cmd_next[1],
            cmd_next[0],
            pat_next[1],
            pat_next[0],
            coil_next[1],
            coil_next[0]
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg <= 1'b1;
            for (int k = 0; k < 2; k++)
            begin
                cmd_reg[k]  <= CMD_STOP;
                rem_reg[k]  <= '0;
                pos_reg[k]  <= '0;
                idx_reg[k]  <= '0;
                swc_reg[k]  <= '0;
                coil_reg[k] <= 1'b0;
                pat_reg[k]  <= '0;
            end
        end
        else
        begin
            served_reg <= served_next;
            cmd_reg    <= cmd_next;
            rem_reg    <= rem_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            swc_reg    <= swc_next;
            coil_reg   <= coil_next;
            pat_reg    <= pat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a raised home-fail flag always belongs to a motor that is now stopped
    a_fail_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[OUT_USED_BITS-1] |-> cmd_reg[served_reg] == CMD_STOP)
        else $error("home_fail shown while served motor still running");

    // every tick switches to the other motor
    a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_mode_reg |=> served_reg != $past(served_reg))
        else $error("tick did not alternate motors");

    // a command load leaves the served motor pointer alone
    a_cmd_keeps_served: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_mode_reg |=> served_reg == $past(served_reg))
        else $error("command word changed served motor");

    // a stalled input word stays in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_steps_reg))
        else $error("input word lost during stall");
`endif

endmodule
